>>> hdl/acks_pkg.sv
// ----------------------------------------------------------------------------
// acks_pkg
// Shared constants, types and helper functions of the Ackermann steering
// split pipeline.
// ----------------------------------------------------------------------------
package acks_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ANGLE_WIDTH   = 16;

   localparam int N_ST     = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
   localparam int ANG_FRAC = ANGLE_WIDTH - 3;
   localparam int ZW       = ANGLE_WIDTH + 2;

   localparam int CMD_W  = 16;
   localparam int DB_W   = 14;
   localparam int AM_W   = 14;
   localparam int LIM_W  = 15;
   localparam int LEN_W  = 16;
   localparam int AMIN_W = 15;
   localparam int AMAX_W = 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam int PROD1_W = CMD_W + LIM_W;
   localparam int ROT_W   = 31;
   localparam int PROD_W  = 49;
   localparam int DEN_W   = 50;
   localparam int VEC_W   = 53;
   localparam int DIV_SH  = 28 - ANG_FRAC;
   localparam int NUM_W   = 34;
   localparam int Q_W     = 16;

   localparam int AF_UP  = (ANG_FRAC >= 13) ? ANG_FRAC - 13 : 0;
   localparam int AF_DN  = (ANG_FRAC >= 13) ? 0 : 13 - ANG_FRAC;
   localparam int AF_RND = (AF_DN > 0) ? (1 << (AF_DN - 1)) : 0;

   localparam int ATAN_SH = 30 - ANG_FRAC;

   localparam logic [AM_W-1:0] HALF_PI_Q13 = AM_W'(12868);
   localparam logic signed [ZW-1:0] HALF_PI_AF =
      ZW'((64'd1686629713 + (64'd1 << (ATAN_SH - 1))) >> ATAN_SH);
   localparam logic signed [ROT_W-1:0] XY_START = ROT_W'(268435456);

   localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sh7FFF;
   localparam logic signed [CMD_W-1:0] CMD_MIN = -16'sh8000;

   localparam logic [31:0] ATAN_Q30 [24] = '{
      32'd843314857, 32'd497837829, 32'd263043836, 32'd133525159,
      32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
      32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
      32'd262144,    32'd131072,    32'd65536,     32'd32768,
      32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WHEEL_BASE,
      CSR_TRACK_WIDTH,
      CSR_STEER_MIN,
      CSR_STEER_MAX,
      CSR_LEFT_MIN,
      CSR_LEFT_MAX,
      CSR_RIGHT_MIN,
      CSR_RIGHT_MAX
   } csr_index_type;

   typedef struct packed {
      logic neg;
      logic straight;
      logic zero_ang;
   } meta_type;

   typedef struct packed {
      meta_type             meta;
      logic [1:0]           ovr;
      logic [1:0][ZW-1:0]   oval;
   } vtag_type;

   typedef struct packed {
      logic       straight;
      logic [1:0] sat;
      logic [1:0] zres;
      logic [1:0] sgn;
   } dtag_type;

   function automatic logic signed [ZW-1:0] atan_af(input int idx);
      logic [32:0] t;
      t = {1'b0, ATAN_Q30[idx]} + (33'd1 << (ATAN_SH - 1));
      return ZW'(t >> ATAN_SH);
   endfunction

   function automatic logic [LIM_W-1:0] neg_limit_mag(input logic [AMIN_W-1:0] v);
      logic [LIM_W:0] d;
      d = 16'h8000 - {1'b0, v};
      return v[AMIN_W-1] ? d[LIM_W-1:0] : v;
   endfunction

   function automatic logic signed [ZW-1:0] to_af(input logic [AM_W-1:0] am);
      logic [31:0] w;
      w = (32'(am) << AF_UP) + 32'(AF_RND);
      return ZW'(w >> AF_DN);
   endfunction

endpackage

>>> hdl/acks_rotator.sv
// ----------------------------------------------------------------------------
// acks_rotator
// Rotation-mode CORDIC, one micro-rotation per register stage; produces
// the unscaled cosine and sine of the steering angle.
// ----------------------------------------------------------------------------
module acks_rotator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [acks_pkg::ZW-1:0]        in_z,
   input  acks_pkg::meta_type                    in_meta,
   output logic                                  out_valid,
   output logic signed [acks_pkg::ROT_W-1:0]     out_cos,
   output logic signed [acks_pkg::ROT_W-1:0]     out_sin,
   output acks_pkg::meta_type                    out_meta
);

   logic [acks_pkg::N_ST-1:0]                v_ff;
   logic [acks_pkg::N_ST-1:0]                v_in;
   logic signed [acks_pkg::ROT_W-1:0]        x_ff  [acks_pkg::N_ST];
   logic signed [acks_pkg::ROT_W-1:0]        y_ff  [acks_pkg::N_ST];
   logic signed [acks_pkg::ZW-1:0]           z_ff  [acks_pkg::N_ST];
   acks_pkg::meta_type                       m_ff  [acks_pkg::N_ST];
   logic signed [acks_pkg::ROT_W-1:0]        x_in  [acks_pkg::N_ST];
   logic signed [acks_pkg::ROT_W-1:0]        y_in  [acks_pkg::N_ST];
   logic signed [acks_pkg::ZW-1:0]           z_in  [acks_pkg::N_ST];
   acks_pkg::meta_type                       m_in  [acks_pkg::N_ST];
   logic signed [acks_pkg::ROT_W-1:0]        sx    [acks_pkg::N_ST];
   logic signed [acks_pkg::ROT_W-1:0]        sy    [acks_pkg::N_ST];
   logic signed [acks_pkg::ZW-1:0]           sz    [acks_pkg::N_ST];

   always_comb begin
      sx[0]   = acks_pkg::XY_START;
      sy[0]   = '0;
      sz[0]   = in_z;
      v_in[0] = in_valid;
      m_in[0] = in_meta;
      for (int k = 1; k < acks_pkg::N_ST; k++) begin
         sx[k]   = x_ff[k-1];
         sy[k]   = y_ff[k-1];
         sz[k]   = z_ff[k-1];
         v_in[k] = v_ff[k-1];
         m_in[k] = m_ff[k-1];
      end
      for (int k = 0; k < acks_pkg::N_ST; k++) begin
         if (sz[k] >= 0) begin
            x_in[k] = sx[k] - (sy[k] >>> k);
            y_in[k] = sy[k] + (sx[k] >>> k);
            z_in[k] = sz[k] - acks_pkg::atan_af(k);
         end else begin
            x_in[k] = sx[k] + (sy[k] >>> k);
            y_in[k] = sy[k] - (sx[k] >>> k);
            z_in[k] = sz[k] + acks_pkg::atan_af(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < acks_pkg::N_ST; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
            m_ff[k] <= m_in[k];
         end
      end
   end

   assign out_valid = v_ff[acks_pkg::N_ST-1];
   assign out_cos   = x_ff[acks_pkg::N_ST-1];
   assign out_sin   = y_ff[acks_pkg::N_ST-1];
   assign out_meta  = m_ff[acks_pkg::N_ST-1];

endmodule

>>> hdl/acks_vectorer.sv
// ----------------------------------------------------------------------------
// acks_vectorer
// Two-lane vectoring-mode CORDIC, one micro-rotation per register stage;
// returns the inner and outer wheel arctangents.
// ----------------------------------------------------------------------------
module acks_vectorer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [acks_pkg::VEC_W-1:0]     in_x [2],
   input  logic signed [acks_pkg::VEC_W-1:0]     in_y [2],
   input  acks_pkg::vtag_type                    in_tag,
   output logic                                  out_valid,
   output logic signed [acks_pkg::ZW-1:0]        out_z [2],
   output acks_pkg::vtag_type                    out_tag
);

   logic [acks_pkg::N_ST-1:0]                v_ff;
   logic [acks_pkg::N_ST-1:0]                v_in;
   logic signed [acks_pkg::VEC_W-1:0]        x_ff [acks_pkg::N_ST][2];
   logic signed [acks_pkg::VEC_W-1:0]        y_ff [acks_pkg::N_ST][2];
   logic signed [acks_pkg::ZW-1:0]           z_ff [acks_pkg::N_ST][2];
   acks_pkg::vtag_type                       t_ff [acks_pkg::N_ST];
   logic signed [acks_pkg::VEC_W-1:0]        x_in [acks_pkg::N_ST][2];
   logic signed [acks_pkg::VEC_W-1:0]        y_in [acks_pkg::N_ST][2];
   logic signed [acks_pkg::ZW-1:0]           z_in [acks_pkg::N_ST][2];
   acks_pkg::vtag_type                       t_in [acks_pkg::N_ST];
   logic signed [acks_pkg::VEC_W-1:0]        sx   [acks_pkg::N_ST][2];
   logic signed [acks_pkg::VEC_W-1:0]        sy   [acks_pkg::N_ST][2];
   logic signed [acks_pkg::ZW-1:0]           sz   [acks_pkg::N_ST][2];

   always_comb begin
      v_in[0] = in_valid;
      t_in[0] = in_tag;
      for (int l = 0; l < 2; l++) begin
         sx[0][l] = in_x[l];
         sy[0][l] = in_y[l];
         sz[0][l] = '0;
      end
      for (int k = 1; k < acks_pkg::N_ST; k++) begin
         v_in[k] = v_ff[k-1];
         t_in[k] = t_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            sx[k][l] = x_ff[k-1][l];
            sy[k][l] = y_ff[k-1][l];
            sz[k][l] = z_ff[k-1][l];
         end
      end
      for (int k = 0; k < acks_pkg::N_ST; k++) begin
         for (int l = 0; l < 2; l++) begin
            if (sy[k][l] >= 0) begin
               x_in[k][l] = sx[k][l] + (sy[k][l] >>> k);
               y_in[k][l] = sy[k][l] - (sx[k][l] >>> k);
               z_in[k][l] = sz[k][l] + acks_pkg::atan_af(k);
            end else begin
               x_in[k][l] = sx[k][l] - (sy[k][l] >>> k);
               y_in[k][l] = sy[k][l] + (sx[k][l] >>> k);
               z_in[k][l] = sz[k][l] - acks_pkg::atan_af(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < acks_pkg::N_ST; k++) begin
            t_ff[k] <= t_in[k];
            for (int l = 0; l < 2; l++) begin
               x_ff[k][l] <= x_in[k][l];
               y_ff[k][l] <= y_in[k][l];
               z_ff[k][l] <= z_in[k][l];
            end
         end
      end
   end

   assign out_valid = v_ff[acks_pkg::N_ST-1];
   assign out_z[0]  = z_ff[acks_pkg::N_ST-1][0];
   assign out_z[1]  = z_ff[acks_pkg::N_ST-1][1];
   assign out_tag   = t_ff[acks_pkg::N_ST-1];

endmodule

>>> hdl/acks_divider.sv
// ----------------------------------------------------------------------------
// acks_divider
// Two-lane restoring divider, one quotient bit per register stage; turns
// wheel angle magnitudes into command magnitudes.
// ----------------------------------------------------------------------------
module acks_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [acks_pkg::NUM_W-1:0]            in_num [2],
   input  logic [acks_pkg::LIM_W-1:0]            in_lim [2],
   input  acks_pkg::dtag_type                    in_tag,
   output logic                                  out_valid,
   output logic [acks_pkg::Q_W-1:0]              out_q [2],
   output acks_pkg::dtag_type                    out_tag
);

   logic [acks_pkg::Q_W-1:0]             v_ff;
   logic [acks_pkg::Q_W-1:0]             v_in;
   logic [acks_pkg::NUM_W-1:0]           r_ff  [acks_pkg::Q_W][2];
   logic [acks_pkg::LIM_W-1:0]           d_ff  [acks_pkg::Q_W][2];
   logic [acks_pkg::Q_W-1:0]             q_ff  [acks_pkg::Q_W][2];
   acks_pkg::dtag_type                   t_ff  [acks_pkg::Q_W];
   logic [acks_pkg::NUM_W-1:0]           r_in  [acks_pkg::Q_W][2];
   logic [acks_pkg::Q_W-1:0]             q_in  [acks_pkg::Q_W][2];
   acks_pkg::dtag_type                   t_in  [acks_pkg::Q_W];
   logic [acks_pkg::NUM_W-1:0]           sr    [acks_pkg::Q_W][2];
   logic [acks_pkg::LIM_W-1:0]           sd    [acks_pkg::Q_W][2];
   logic [acks_pkg::Q_W-1:0]             sq    [acks_pkg::Q_W][2];
   logic [acks_pkg::NUM_W-1:0]           trial [acks_pkg::Q_W][2];

   always_comb begin
      v_in[0] = in_valid;
      t_in[0] = in_tag;
      for (int l = 0; l < 2; l++) begin
         sr[0][l] = in_num[l];
         sd[0][l] = in_lim[l];
         sq[0][l] = '0;
      end
      for (int k = 1; k < acks_pkg::Q_W; k++) begin
         v_in[k] = v_ff[k-1];
         t_in[k] = t_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            sr[k][l] = r_ff[k-1][l];
            sd[k][l] = d_ff[k-1][l];
            sq[k][l] = q_ff[k-1][l];
         end
      end
      for (int k = 0; k < acks_pkg::Q_W; k++) begin
         for (int l = 0; l < 2; l++) begin
            trial[k][l] = acks_pkg::NUM_W'(sd[k][l]) << (acks_pkg::Q_W - 1 - k);
            q_in[k][l]  = sq[k][l];
            if (sr[k][l] >= trial[k][l]) begin
               r_in[k][l] = sr[k][l] - trial[k][l];
               q_in[k][l][acks_pkg::Q_W-1-k] = 1'b1;
            end else begin
               r_in[k][l] = sr[k][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < acks_pkg::Q_W; k++) begin
            t_ff[k] <= t_in[k];
            for (int l = 0; l < 2; l++) begin
               r_ff[k][l] <= r_in[k][l];
               d_ff[k][l] <= sd[k][l];
               q_ff[k][l] <= q_in[k][l];
            end
         end
      end
   end

   assign out_valid = v_ff[acks_pkg::Q_W-1];
   assign out_q[0]  = q_ff[acks_pkg::Q_W-1][0];
   assign out_q[1]  = q_ff[acks_pkg::Q_W-1][1];
   assign out_tag   = t_ff[acks_pkg::Q_W-1];

endmodule

>>> hdl/ackermann_steering_split.sv
// ----------------------------------------------------------------------------
// ackermann_steering_split
// Splits a normalized steering command into left and right wheel commands
// by Ackermann geometry.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock while req_stall is low. The path
// runs through the two CORDIC chains (16 stages each, sine/cosine then
// both wheel arctangents in parallel) and the 16-stage restoring divider
// that maps wheel angles back to commands, plus nine stages of mapping,
// products and saturation. The output has two entries (register plus skid);
// while the skid holds a result the pipeline stalls and req_stall is high.
// Configuration is always taken; write it only while the pipeline is empty.
// ----------------------------------------------------------------------------
module ackermann_steering_split (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [acks_pkg::CMD_W-1:0]       req_steer_cmd,
   input  logic [acks_pkg::DB_W-1:0]               req_dead_band,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [acks_pkg::CMD_W-1:0]       rsp_left_cmd,
   output logic signed [acks_pkg::CMD_W-1:0]       rsp_right_cmd,
   output logic                                    rsp_straight,
   output logic                                    rsp_clipped,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [acks_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [acks_pkg::CSR_DAT_W-1:0]          csr_data
);

   // configuration
   logic [acks_pkg::LEN_W-1:0]   wheel_base_ff;
   logic [acks_pkg::LEN_W-1:0]   track_width_ff;
   logic [acks_pkg::AMIN_W-1:0]  steer_min_ff;
   logic [acks_pkg::AMAX_W-1:0]  steer_max_ff;
   logic [acks_pkg::AMIN_W-1:0]  left_min_ff;
   logic [acks_pkg::AMAX_W-1:0]  left_max_ff;
   logic [acks_pkg::AMIN_W-1:0]  right_min_ff;
   logic [acks_pkg::AMAX_W-1:0]  right_max_ff;

   logic en;

   // stage 1
   logic                           s1_v_ff;
   logic                           s1_neg_ff, s1_neg_in;
   logic [acks_pkg::PROD1_W-1:0]   s1_prod_ff, s1_prod_in;
   logic [acks_pkg::DB_W-1:0]      s1_db_ff;
   logic [acks_pkg::CMD_W-1:0]     s1_cm;
   logic [acks_pkg::LIM_W-1:0]     s1_lim;

   // stage 2
   logic                           s2_v_ff;
   acks_pkg::meta_type             s2_meta_ff, s2_meta_in;
   logic signed [acks_pkg::ZW-1:0] s2_z_ff, s2_z_in;
   logic [acks_pkg::PROD1_W:0]     s2_sum;
   logic [acks_pkg::AM_W-1:0]      s2_am;

   // rotator
   logic                               rot_v;
   logic signed [acks_pkg::ROT_W-1:0]  rot_cos, rot_sin;
   acks_pkg::meta_type                 rot_meta;

   // stage 3
   logic                                s3_v_ff;
   acks_pkg::meta_type                  s3_meta_ff;
   logic signed [acks_pkg::PROD_W-1:0]  s3_num_ff, s3_num_in;
   logic signed [acks_pkg::PROD_W-1:0]  s3_wbco_ff, s3_wbco_in;
   logic signed [acks_pkg::PROD_W-1:0]  s3_ts_ff, s3_ts_in;
   logic signed [acks_pkg::PROD_W-1:0]  s3_wb2, s3_tw;

   // stage 4
   logic                                s4_v_ff;
   acks_pkg::meta_type                  s4_meta_ff;
   logic signed [acks_pkg::PROD_W-1:0]  s4_num_ff;
   logic signed [acks_pkg::DEN_W-1:0]   s4_den_ff [2];
   logic signed [acks_pkg::DEN_W-1:0]   s4_den_in [2];

   // stage 5
   logic                                s5_v_ff;
   acks_pkg::vtag_type                  s5_tag_ff, s5_tag_in;
   logic signed [acks_pkg::VEC_W-1:0]   s5_x_ff [2];
   logic signed [acks_pkg::VEC_W-1:0]   s5_y_ff [2];
   logic signed [acks_pkg::VEC_W-1:0]   s5_x_in [2];
   logic signed [acks_pkg::VEC_W-1:0]   s5_y_in [2];
   logic signed [acks_pkg::VEC_W-1:0]   s5_num;

   // vectorer
   logic                                vec_v;
   logic signed [acks_pkg::ZW-1:0]      vec_z [2];
   acks_pkg::vtag_type                  vec_tag;

   // stage 6
   logic                                s6_v_ff;
   logic                                s6_straight_ff;
   logic signed [acks_pkg::ZW-1:0]      s6_ang_ff [2];
   logic signed [acks_pkg::ZW-1:0]      s6_ang_in [2];
   logic signed [acks_pkg::ZW-1:0]      s6_inner, s6_outer;

   // stage 7
   logic                                s7_v_ff;
   logic                                s7_straight_ff;
   logic [1:0]                          s7_sgn_ff, s7_sgn_in;
   logic [acks_pkg::ZW-1:0]             s7_mag_ff [2];
   logic [acks_pkg::ZW-1:0]             s7_mag_in [2];
   logic [acks_pkg::LIM_W-1:0]          s7_lim_ff [2];
   logic [acks_pkg::LIM_W-1:0]          s7_lim_in [2];

   // stage 8
   logic                                s8_v_ff;
   acks_pkg::dtag_type                  s8_tag_ff, s8_tag_in;
   logic [acks_pkg::NUM_W-1:0]          s8_num_ff [2];
   logic [acks_pkg::NUM_W-1:0]          s8_num_in [2];
   logic [acks_pkg::LIM_W-1:0]          s8_lim_ff [2];
   logic [acks_pkg::NUM_W-1:0]          s8_top [2];

   // divider
   logic                                div_v;
   logic [acks_pkg::Q_W-1:0]            div_q [2];
   acks_pkg::dtag_type                  div_tag;

   // output register and skid
   logic                                out_v_ff;
   logic signed [acks_pkg::CMD_W-1:0]   out_left_ff, out_right_ff;
   logic                                out_straight_ff, out_clipped_ff;
   logic signed [acks_pkg::CMD_W-1:0]   out_cmd_in [2];
   logic                                out_clipped_in;
   logic                                skid_v_ff, skid_v_in;
   logic signed [acks_pkg::CMD_W-1:0]   skid_left_ff, skid_right_ff;
   logic                                skid_straight_ff, skid_clipped_ff;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_base_ff  <= 16'd1000;
         track_width_ff <= 16'd800;
         steer_min_ff   <= 15'h7000;
         steer_max_ff   <= 14'd4096;
         left_min_ff    <= 15'h7000;
         left_max_ff    <= 14'd4096;
         right_min_ff   <= 15'h7000;
         right_max_ff   <= 14'd4096;
      end else if (csr_valid && csr_ready) begin
         unique case (acks_pkg::csr_index_type'(csr_index))
            acks_pkg::CSR_WHEEL_BASE:  wheel_base_ff  <= csr_data;
            acks_pkg::CSR_TRACK_WIDTH: track_width_ff <= csr_data;
            acks_pkg::CSR_STEER_MIN:   steer_min_ff   <= csr_data[acks_pkg::AMIN_W-1:0];
            acks_pkg::CSR_STEER_MAX:   steer_max_ff   <= csr_data[acks_pkg::AMAX_W-1:0];
            acks_pkg::CSR_LEFT_MIN:    left_min_ff    <= csr_data[acks_pkg::AMIN_W-1:0];
            acks_pkg::CSR_LEFT_MAX:    left_max_ff    <= csr_data[acks_pkg::AMAX_W-1:0];
            acks_pkg::CSR_RIGHT_MIN:   right_min_ff   <= csr_data[acks_pkg::AMIN_W-1:0];
            acks_pkg::CSR_RIGHT_MAX:   right_max_ff   <= csr_data[acks_pkg::AMAX_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // pipeline control
   // ------------------------------------------------------------------------
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         s8_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff  <= req_valid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= rot_v;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         s6_v_ff  <= vec_v;
         s7_v_ff  <= s6_v_ff;
         s8_v_ff  <= s7_v_ff;
         out_v_ff <= div_v;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: command magnitude times steering limit
   // ------------------------------------------------------------------------
   always_comb begin
      s1_neg_in  = req_steer_cmd[acks_pkg::CMD_W-1];
      s1_cm      = s1_neg_in ? acks_pkg::CMD_W'(-req_steer_cmd) : req_steer_cmd;
      s1_lim     = s1_neg_in ? acks_pkg::neg_limit_mag(steer_min_ff)
                             : acks_pkg::LIM_W'(steer_max_ff);
      s1_prod_in = acks_pkg::PROD1_W'(s1_cm) * acks_pkg::PROD1_W'(s1_lim);
   end

   // ------------------------------------------------------------------------
   // stage 2: round, clamp to pi/2, dead band
   // ------------------------------------------------------------------------
   always_comb begin
      s2_sum = {1'b0, s1_prod_ff} + (acks_pkg::PROD1_W + 1)'(16384);
      if (s2_sum[acks_pkg::PROD1_W:15] > (acks_pkg::PROD1_W - 14)'(acks_pkg::HALF_PI_Q13)) begin
         s2_am = acks_pkg::HALF_PI_Q13;
      end else begin
         s2_am = s2_sum[acks_pkg::AM_W+14:15];
      end
      s2_z_in             = acks_pkg::to_af(s2_am);
      s2_meta_in.neg      = s1_neg_ff;
      s2_meta_in.straight = (s2_am < s1_db_ff);
      s2_meta_in.zero_ang = (s2_z_in == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_neg_ff  <= s1_neg_in;
         s1_prod_ff <= s1_prod_in;
         s1_db_ff   <= req_dead_band;
         s2_meta_ff <= s2_meta_in;
         s2_z_ff    <= s2_z_in;
      end
   end

   acks_rotator u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_v_ff),
      .in_z      (s2_z_ff),
      .in_meta   (s2_meta_ff),
      .out_valid (rot_v),
      .out_cos   (rot_cos),
      .out_sin   (rot_sin),
      .out_meta  (rot_meta)
   );

   // ------------------------------------------------------------------------
   // stage 3: geometry products
   // ------------------------------------------------------------------------
   always_comb begin
      s3_wb2     = acks_pkg::PROD_W'({1'b0, wheel_base_ff, 1'b0});
      s3_tw      = acks_pkg::PROD_W'({1'b0, track_width_ff});
      s3_num_in  = s3_wb2 * acks_pkg::PROD_W'(rot_sin);
      s3_wbco_in = s3_wb2 * acks_pkg::PROD_W'(rot_cos);
      s3_ts_in   = s3_tw * acks_pkg::PROD_W'(rot_sin);
   end

   // ------------------------------------------------------------------------
   // stage 4: inner and outer denominators
   // ------------------------------------------------------------------------
   assign s4_den_in[0] = acks_pkg::DEN_W'(s3_wbco_ff) - acks_pkg::DEN_W'(s3_ts_ff);
   assign s4_den_in[1] = acks_pkg::DEN_W'(s3_wbco_ff) + acks_pkg::DEN_W'(s3_ts_ff);

   // ------------------------------------------------------------------------
   // stage 5: fold into the right half plane, flag special angles
   // ------------------------------------------------------------------------
   always_comb begin
      s5_num         = acks_pkg::VEC_W'(s4_num_ff);
      s5_tag_in.meta = s4_meta_ff;
      for (int l = 0; l < 2; l++) begin
         if (s4_den_ff[l] < 0) begin
            s5_x_in[l] = -acks_pkg::VEC_W'(s4_den_ff[l]);
            s5_y_in[l] = -s5_num;
         end else begin
            s5_x_in[l] = acks_pkg::VEC_W'(s4_den_ff[l]);
            s5_y_in[l] = s5_num;
         end
         s5_tag_in.ovr[l] = s4_meta_ff.zero_ang || (s4_den_ff[l] == '0);
         if (s4_meta_ff.zero_ang) begin
            s5_tag_in.oval[l] = '0;
         end else if (s4_num_ff > 0) begin
            s5_tag_in.oval[l] = acks_pkg::HALF_PI_AF;
         end else if (s4_num_ff < 0) begin
            s5_tag_in.oval[l] = -acks_pkg::HALF_PI_AF;
         end else begin
            s5_tag_in.oval[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_meta_ff <= rot_meta;
         s3_num_ff  <= s3_num_in;
         s3_wbco_ff <= s3_wbco_in;
         s3_ts_ff   <= s3_ts_in;
         s4_meta_ff <= s3_meta_ff;
         s4_num_ff  <= s3_num_ff;
         s5_tag_ff  <= s5_tag_in;
         for (int l = 0; l < 2; l++) begin
            s4_den_ff[l] <= s4_den_in[l];
            s5_x_ff[l]   <= s5_x_in[l];
            s5_y_ff[l]   <= s5_y_in[l];
         end
      end
   end

   acks_vectorer u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_v_ff),
      .in_x      (s5_x_ff),
      .in_y      (s5_y_ff),
      .in_tag    (s5_tag_ff),
      .out_valid (vec_v),
      .out_z     (vec_z),
      .out_tag   (vec_tag)
   );

   // ------------------------------------------------------------------------
   // stage 6: assign inner/outer to left/right
   // ------------------------------------------------------------------------
   always_comb begin
      s6_inner = vec_tag.ovr[0] ? signed'(vec_tag.oval[0]) : vec_z[0];
      s6_outer = vec_tag.ovr[1] ? signed'(vec_tag.oval[1]) : vec_z[1];
      if (vec_tag.meta.neg) begin
         s6_ang_in[0] = -s6_outer;
         s6_ang_in[1] = -s6_inner;
      end else begin
         s6_ang_in[0] = s6_inner;
         s6_ang_in[1] = s6_outer;
      end
   end

   // ------------------------------------------------------------------------
   // stage 7: magnitude and wheel limit
   // ------------------------------------------------------------------------
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         s7_sgn_in[l] = s6_ang_ff[l][acks_pkg::ZW-1];
         s7_mag_in[l] = s7_sgn_in[l] ? acks_pkg::ZW'(-s6_ang_ff[l]) : s6_ang_ff[l];
      end
      s7_lim_in[0] = s7_sgn_in[0] ? acks_pkg::neg_limit_mag(left_min_ff)
                                  : acks_pkg::LIM_W'(left_max_ff);
      s7_lim_in[1] = s7_sgn_in[1] ? acks_pkg::neg_limit_mag(right_min_ff)
                                  : acks_pkg::LIM_W'(right_max_ff);
   end

   // ------------------------------------------------------------------------
   // stage 8: dividend and saturation check
   // ------------------------------------------------------------------------
   always_comb begin
      s8_tag_in.straight = s7_straight_ff;
      s8_tag_in.sgn      = s7_sgn_ff;
      for (int l = 0; l < 2; l++) begin
         s8_num_in[l] = (acks_pkg::NUM_W'(s7_mag_ff[l]) << acks_pkg::DIV_SH)
                      + acks_pkg::NUM_W'(s7_lim_ff[l] >> 1);
         s8_top[l]    = acks_pkg::NUM_W'(s7_lim_ff[l]) << (acks_pkg::CMD_W - 1);
         if (s7_lim_ff[l] == '0) begin
            s8_tag_in.sat[l]  = (s7_mag_ff[l] != '0);
            s8_tag_in.zres[l] = (s7_mag_ff[l] == '0);
         end else begin
            s8_tag_in.zres[l] = 1'b0;
            if (s7_sgn_ff[l]) begin
               s8_tag_in.sat[l] = (s8_num_in[l] >= s8_top[l] + acks_pkg::NUM_W'(s7_lim_ff[l]));
            end else begin
               s8_tag_in.sat[l] = (s8_num_in[l] >= s8_top[l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_straight_ff <= vec_tag.meta.straight;
         s7_straight_ff <= s6_straight_ff;
         s7_sgn_ff      <= s7_sgn_in;
         s8_tag_ff      <= s8_tag_in;
         for (int l = 0; l < 2; l++) begin
            s6_ang_ff[l] <= s6_ang_in[l];
            s7_mag_ff[l] <= s7_mag_in[l];
            s7_lim_ff[l] <= s7_lim_in[l];
            s8_num_ff[l] <= s8_num_in[l];
            s8_lim_ff[l] <= s7_lim_ff[l];
         end
      end
   end

   acks_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_v_ff),
      .in_num    (s8_num_ff),
      .in_lim    (s8_lim_ff),
      .in_tag    (s8_tag_ff),
      .out_valid (div_v),
      .out_q     (div_q),
      .out_tag   (div_tag)
   );

   // ------------------------------------------------------------------------
   // stage 9: sign, saturate, output register
   // ------------------------------------------------------------------------
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (div_tag.straight || div_tag.zres[l]) begin
            out_cmd_in[l] = '0;
         end else if (div_tag.sat[l]) begin
            out_cmd_in[l] = div_tag.sgn[l] ? acks_pkg::CMD_MIN : acks_pkg::CMD_MAX;
         end else if (div_tag.sgn[l]) begin
            out_cmd_in[l] = -signed'(div_q[l]);
         end else begin
            out_cmd_in[l] = signed'(div_q[l]);
         end
      end
      out_clipped_in = !div_tag.straight && (div_tag.sat != 2'b00);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_left_ff     <= out_cmd_in[0];
         out_right_ff    <= out_cmd_in[1];
         out_straight_ff <= div_tag.straight;
         out_clipped_ff  <= out_clipped_in;
      end
   end

   // ------------------------------------------------------------------------
   // skid: hold the output register's result while the pipeline advances
   // ------------------------------------------------------------------------
   assign skid_v_in = skid_v_ff ? rsp_stall : (out_v_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_left_ff     <= out_left_ff;
         skid_right_ff    <= out_right_ff;
         skid_straight_ff <= out_straight_ff;
         skid_clipped_ff  <= out_clipped_ff;
      end
   end

   assign rsp_valid     = skid_v_ff || out_v_ff;
   assign rsp_left_cmd  = skid_v_ff ? skid_left_ff     : out_left_ff;
   assign rsp_right_cmd = skid_v_ff ? skid_right_ff    : out_right_ff;
   assign rsp_straight  = skid_v_ff ? skid_straight_ff : out_straight_ff;
   assign rsp_clipped   = skid_v_ff ? skid_clipped_ff  : out_clipped_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_straight_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_straight |-> rsp_left_cmd == '0 && rsp_right_cmd == '0 && !rsp_clipped)
      else $error("straight result carries nonzero commands");

   a_clip_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_left_cmd == acks_pkg::CMD_MAX || rsp_left_cmd == acks_pkg::CMD_MIN ||
         rsp_right_cmd == acks_pkg::CMD_MAX || rsp_right_cmd == acks_pkg::CMD_MIN)
      else $error("clipped flag without a saturated command");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_stall |=> !skid_v_ff)
      else $error("skid entry not released after delivery");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(out_v_ff) && $stable(out_left_ff) && $stable(out_right_ff))
      else $error("output register changed while skid held a result");

endmodule
